// ----- rtl/core/zdt_pkg.sv -----
// Shared types and codes for the zone dwell timer table.
// Holds the request/response payloads, table command flags and slot layout.
// No dependencies.
`default_nettype none

package zdt_pkg;

   // Operation codes of a request
   localparam logic [1:0] OP_OBSERVE = 2'd0;
   localparam logic [1:0] OP_SWEEP   = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   // Result status codes
   localparam logic STATUS_LOITER = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] CSR_LOITER_MS   = 3'd0;
   localparam logic [2:0] CSR_CLASS_COUNT = 3'd1;
   localparam logic [2:0] CSR_CLASS_A     = 3'd2;
   localparam logic [2:0] CSR_CLASS_B     = 3'd3;
   localparam logic [2:0] CSR_CLASS_C     = 3'd4;
   localparam logic [2:0] CSR_CLASS_D     = 3'd5;

   // Number of allowed-class registers
   localparam int CLASS_REGS = 4;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] track_id;
      logic [7:0]  class_id;
      logic        in_zone;
      logic [31:0] frame_time;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] event_track;
      logic [7:0]  event_class;
      logic [31:0] dwell_ms;
   } rsp_type;

   // One table slot as kept in memory
   typedef struct packed {
      logic [31:0] track;
      logic [31:0] entered;
      logic        fired;
   } slot_type;

   // Table update command, all flags act on one slot index except clear/sweep
   typedef struct packed {
      logic clear;
      logic sweep;
      logic drop;
      logic mark_seen;
      logic set_valid;
      logic mem_we;
   } tbl_cmd_type;

   // Shared subtract/compare unit result
   typedef struct packed {
      logic [31:0] diff;
      logic        zero;
      logic        no_borrow;
   } alu_res_type;

endpackage

`default_nettype wire

// ----- rtl/core/zdt_alu.sv -----
// Shared 32-bit subtract and compare unit of the zone dwell timer table.
// Depends on zdt_pkg for the result struct.
`default_nettype none

module zdt_alu (
   input  wire logic [31:0]          a,
   input  wire logic [31:0]          b,
   output zdt_pkg::alu_res_type      res
);

   logic [32:0] sum;

   // Subtract with borrow out; zero difference doubles as equality
   always_comb begin
      sum           = {1'b0, a} + {1'b0, ~b} + 33'd1;
      res.diff      = sum[31:0];
      res.no_borrow = sum[32];
      res.zero      = (sum[31:0] == 32'd0);
   end

endmodule

`default_nettype wire

// ----- rtl/core/zdt_table.sv -----
// Slot storage of the zone dwell timer table: valid and seen flags in flops,
// track, entry time and fired mark in a memory with a registered read port.
// Depends on zdt_pkg for slot and command types.
`default_nettype none

module zdt_table #(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire zdt_pkg::tbl_cmd_type             cmd,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] cmd_idx,
   input  wire zdt_pkg::slot_type                wr_slot,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   output zdt_pkg::slot_type                     rd_slot,
   output logic                                  rd_valid,
   output logic [$clog2(TABLE_ENTRIES)-1:0]      rd_idx
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   zdt_pkg::slot_type        mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [TABLE_ENTRIES-1:0] seen_ff, seen_in;
   zdt_pkg::slot_type        rd_slot_ff;
   logic                     rd_valid_ff;
   logic [IDX_W-1:0]         rd_idx_ff;

   // Flag updates: clear, end-of-frame sweep, or a single-slot change
   always_comb begin
      valid_in = valid_ff;
      seen_in  = seen_ff;
      if (cmd.clear) begin
         valid_in = '0;
         seen_in  = '0;
      end else if (cmd.sweep) begin
         valid_in = valid_ff & seen_ff;
         seen_in  = '0;
      end else begin
         if (cmd.drop) begin
            valid_in[cmd_idx] = 1'b0;
            seen_in[cmd_idx]  = 1'b0;
         end
         if (cmd.set_valid) begin
            valid_in[cmd_idx] = 1'b1;
         end
         if (cmd.mark_seen) begin
            seen_in[cmd_idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         seen_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         seen_ff  <= seen_in;
      end
   end

   // Slot memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[cmd_idx] <= wr_slot;
      end
      rd_slot_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
      rd_idx_ff   <= rd_addr;
   end

   assign rd_slot  = rd_slot_ff;
   assign rd_valid = rd_valid_ff;
   assign rd_idx   = rd_idx_ff;

`ifndef SYNTHESIS
   // A new entry only ever takes a free slot
   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      cmd.set_valid |-> !valid_ff[cmd_idx])
      else $error("allocation into an occupied slot");

   // Drops only hit live entries
   a_drop_live: assert property (@(posedge clock) disable iff (reset)
      cmd.drop |-> valid_ff[cmd_idx])
      else $error("drop of an empty slot");

   // Clear empties every flag
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (valid_ff == '0) && (seen_ff == '0))
      else $error("table not empty after clear");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/zdt_ctrl.sv -----
// Sequencer of the zone dwell timer table: configuration registers, request
// latch, table scan, decision, dwell check and response register.
// Depends on zdt_pkg; drives zdt_table and zdt_alu.
`default_nettype none

module zdt_ctrl #(
   parameter int TABLE_ENTRIES = 64,
   parameter int MAX_CLASSES   = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire zdt_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output zdt_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [2:0]                       csr_index,
   input  wire logic [31:0]                      csr_wdata,
   output zdt_pkg::tbl_cmd_type                  cmd,
   output logic [$clog2(TABLE_ENTRIES)-1:0]      cmd_idx,
   output zdt_pkg::slot_type                     wr_slot,
   output logic [$clog2(TABLE_ENTRIES)-1:0]      rd_addr,
   input  wire zdt_pkg::slot_type                rd_slot,
   input  wire logic                             rd_valid,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] rd_idx,
   output logic [31:0]                           alu_a,
   output logic [31:0]                           alu_b,
   input  wire zdt_pkg::alu_res_type             alu_res
);

   localparam int                 IDX_W     = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W:0]     ENTRY_CNT = (IDX_W+1)'(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0]   ENTRY_TOP = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [2:0]         CLS_MAX   = 3'(MAX_CLASSES);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_CHECK  = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   zdt_pkg::req_type   req_ff, req_in;
   logic [IDX_W:0]     issue_cnt_ff, issue_cnt_in;
   logic               eval_ff, eval_in;
   logic               hit_found_ff, hit_found_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [31:0]        hit_entered_ff, hit_entered_in;
   logic               hit_fired_ff, hit_fired_in;
   logic [31:0]        dwell_ff, dwell_in;
   logic               full_ff, full_in;
   logic               rsp_valid_ff, rsp_valid_in;
   zdt_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [31:0]        loiter_ff, loiter_in;
   logic [2:0]         class_count_ff, class_count_in;
   logic [7:0]         allowed_ff [zdt_pkg::CLASS_REGS];
   logic [7:0]         allowed_in [zdt_pkg::CLASS_REGS];

   logic               accept;
   logic               enabled;
   logic               class_ok;
   logic [2:0]         cls_used;
   logic               issuing;
   logic               rsp_free;

   // Configuration writes
   always_comb begin
      loiter_in      = loiter_ff;
      class_count_in = class_count_ff;
      allowed_in     = allowed_ff;
      if (csr_we) begin
         case (csr_index)
            zdt_pkg::CSR_LOITER_MS:   loiter_in      = csr_wdata;
            zdt_pkg::CSR_CLASS_COUNT: class_count_in = csr_wdata[2:0];
            zdt_pkg::CSR_CLASS_A:     allowed_in[0]  = csr_wdata[7:0];
            zdt_pkg::CSR_CLASS_B:     allowed_in[1]  = csr_wdata[7:0];
            zdt_pkg::CSR_CLASS_C:     allowed_in[2]  = csr_wdata[7:0];
            zdt_pkg::CSR_CLASS_D:     allowed_in[3]  = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Class filter over the active allowed entries
   always_comb begin
      cls_used = (class_count_ff > CLS_MAX) ? CLS_MAX : class_count_ff;
      class_ok = (cls_used == 3'd0);
      for (int j = 0; j < MAX_CLASSES; j++) begin
         if ((3'(j) < cls_used) && (allowed_ff[j] == req_ff.class_id)) begin
            class_ok = 1'b1;
         end
      end
   end

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign enabled  = (loiter_ff != 32'd0);
   assign issuing  = (issue_cnt_ff < ENTRY_CNT);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Operand select for the shared unit
   always_comb begin
      case (state_ff)
         ST_DECIDE: begin
            alu_a = req_ff.frame_time;
            alu_b = hit_entered_ff;
         end
         ST_CHECK: begin
            alu_a = dwell_ff;
            alu_b = loiter_ff;
         end
         default: begin
            alu_a = req_ff.track_id;
            alu_b = rd_slot.track;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      issue_cnt_in   = issue_cnt_ff;
      eval_in        = 1'b0;
      hit_found_in   = hit_found_ff;
      free_found_in  = free_found_ff;
      hit_idx_in     = hit_idx_ff;
      free_idx_in    = free_idx_ff;
      hit_entered_in = hit_entered_ff;
      hit_fired_in   = hit_fired_ff;
      dwell_in       = dwell_ff;
      full_in        = full_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      cmd            = '0;
      cmd_idx        = hit_idx_ff;
      wr_slot        = '{track: req_ff.track_id, entered: req_ff.frame_time, fired: 1'b0};
      rd_addr        = issue_cnt_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               case (req_data.op)
                  zdt_pkg::OP_CLEAR: cmd.clear = 1'b1;
                  zdt_pkg::OP_SWEEP: cmd.sweep = enabled;
                  zdt_pkg::OP_OBSERVE: begin
                     if (enabled) begin
                        state_in      = ST_SCAN;
                        issue_cnt_in  = '0;
                        hit_found_in  = 1'b0;
                        free_found_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle, evaluate the entry read last cycle
            if (issuing) begin
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            eval_in = issuing;
            if (eval_ff) begin
               if (rd_valid) begin
                  if (alu_res.zero && !hit_found_ff) begin
                     hit_found_in   = 1'b1;
                     hit_idx_in     = rd_idx;
                     hit_entered_in = rd_slot.entered;
                     hit_fired_in   = rd_slot.fired;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx;
               end
               if (rd_idx == ENTRY_TOP) begin
                  state_in = ST_DECIDE;
               end
            end
         end

         ST_DECIDE: begin
            if (!req_ff.in_zone || !class_ok) begin
               // Drop the entry of a track that left or is filtered out
               cmd.drop = hit_found_ff;
               state_in = ST_IDLE;
            end else if (!hit_found_ff) begin
               if (!free_found_ff) begin
                  full_in  = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  // New entry: a zero dwell never reaches a nonzero threshold
                  cmd.set_valid = 1'b1;
                  cmd.mark_seen = 1'b1;
                  cmd.mem_we    = 1'b1;
                  cmd_idx       = free_idx_ff;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.mark_seen = 1'b1;
               dwell_in      = alu_res.diff;
               full_in       = 1'b0;
               state_in      = hit_fired_ff ? ST_IDLE : ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (alu_res.no_borrow) begin
               // Threshold reached: mark fired and report
               cmd.mem_we = 1'b1;
               wr_slot    = '{track: req_ff.track_id, entered: hit_entered_ff, fired: 1'b1};
               state_in   = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = full_ff ? zdt_pkg::STATUS_FULL
                                                 : zdt_pkg::STATUS_LOITER;
               rsp_data_in.event_track = req_ff.track_id;
               rsp_data_in.event_class = req_ff.class_id;
               rsp_data_in.dwell_ms    = full_ff ? 32'd0 : dwell_ff;
               state_in                = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         eval_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         loiter_ff      <= '0;
         class_count_ff <= '0;
         for (int j = 0; j < zdt_pkg::CLASS_REGS; j++) begin
            allowed_ff[j] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         eval_ff        <= eval_in;
         rsp_valid_ff   <= rsp_valid_in;
         loiter_ff      <= loiter_in;
         class_count_ff <= class_count_in;
         allowed_ff     <= allowed_in;
      end
   end

   // Payload and scan bookkeeping
   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      issue_cnt_ff   <= issue_cnt_in;
      hit_found_ff   <= hit_found_in;
      free_found_ff  <= free_found_in;
      hit_idx_ff     <= hit_idx_in;
      free_idx_ff    <= free_idx_in;
      hit_entered_ff <= hit_entered_in;
      hit_fired_ff   <= hit_fired_in;
      dwell_ff       <= dwell_in;
      full_ff        <= full_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // A slot cannot be both the matching entry and the first free one
   a_hit_free_apart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && hit_found_ff && free_found_ff
         |-> hit_idx_ff != free_idx_ff)
      else $error("hit and free slot coincide");

   // The dwell check only runs for a live entry that has not fired
   a_check_unfired: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> hit_found_ff && !hit_fired_ff)
      else $error("dwell check on a fired or missing entry");

   // Leaving the emit step always presents a result
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && rsp_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("emit step did not load the response");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/zone_dwell_timer_table.sv -----
// Zone dwell timer table, top level.
// Request channel (req_valid / req_stall / req_data) carries observe, sweep and
// clear operations; a transfer takes place when req_valid is high and
// req_stall is low. Response channel (rsp_valid / rsp_stall / rsp_data) gives
// at most one result per observe: a loiter event or a table-full drop.
// Configuration is a plain write port (csr_we, csr_index, csr_wdata), to be
// written only while the block is idle; the block itself does not enforce it.
// Timing: clear and sweep complete in the accepting cycle. An observe scans
// every slot through the one registered memory read port, one slot a cycle,
// then passes through the decision step, the dwell check when the entry is
// live and has not fired, and the emit step when it has a result to report.
// req_stall is high for that whole time.
// A result sits in the response register; the next request is accepted while
// it waits. If the receiver stalls and a second result is ready, the block
// holds in its emit step until the register frees.
// Synchronous active-high reset empties the table, zeroes all configuration
// (a zero threshold disables the block) and drops any pending result.
// Depends on zdt_pkg, zdt_alu, zdt_table and zdt_ctrl.
`default_nettype none

module zone_dwell_timer_table #(
   parameter int TABLE_ENTRIES = 64,
   parameter int MAX_CLASSES   = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire zdt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output zdt_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   zdt_pkg::tbl_cmd_type cmd;
   logic [IDX_W-1:0]     cmd_idx;
   zdt_pkg::slot_type    wr_slot;
   logic [IDX_W-1:0]     rd_addr;
   zdt_pkg::slot_type    rd_slot;
   logic                 rd_valid;
   logic [IDX_W-1:0]     rd_idx;
   logic [31:0]          alu_a;
   logic [31:0]          alu_b;
   zdt_pkg::alu_res_type alu_res;

   zdt_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_CLASSES   (MAX_CLASSES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .cmd_idx   (cmd_idx),
      .wr_slot   (wr_slot),
      .rd_addr   (rd_addr),
      .rd_slot   (rd_slot),
      .rd_valid  (rd_valid),
      .rd_idx    (rd_idx),
      .alu_a     (alu_a),
      .alu_b     (alu_b),
      .alu_res   (alu_res)
   );

   zdt_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cmd_idx  (cmd_idx),
      .wr_slot  (wr_slot),
      .rd_addr  (rd_addr),
      .rd_slot  (rd_slot),
      .rd_valid (rd_valid),
      .rd_idx   (rd_idx)
   );

   zdt_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

endmodule

`default_nettype wire
